// ----- design/pyuv2rgb_pkg.sv -----
`timescale 1ns / 1ps

package pyuv2rgb_pkg;

    // Byte layout codes of the packed macropixel
    localparam logic [2:0] LAYOUT_YUYV = 3'd0;
    localparam logic [2:0] LAYOUT_YYUV = 3'd1;
    localparam logic [2:0] LAYOUT_YVYU = 3'd2;
    localparam logic [2:0] LAYOUT_UYVY = 3'd3;
    localparam logic [2:0] LAYOUT_VYUY = 3'd4;

    // Output byte order codes
    localparam logic ORDER_RGB = 1'b0;
    localparam logic ORDER_BGR = 1'b1;

    // Configuration register indexes
    localparam logic REG_YUV_LAYOUT = 1'b0;
    localparam logic REG_RGB_ORDER  = 1'b1;

    localparam int CFG_DATA_W = 3;
    localparam int PROD_W     = 26;
    localparam int SCALEBITS  = 16;
    localparam int DELTA_W    = PROD_W - SCALEBITS;
    localparam int SUM_W      = 11;

    localparam logic [7:0] MAXSAMPLE = 8'd255;

    localparam logic signed [PROD_W-1:0] K_CR_R     = 26'sd91881;
    localparam logic signed [PROD_W-1:0] K_CB_B     = 26'sd116130;
    localparam logic signed [PROD_W-1:0] K_CB_G     = 26'sd22554;
    localparam logic signed [PROD_W-1:0] K_CR_G     = 26'sd46802;
    localparam logic signed [PROD_W-1:0] HALF_ROUND = 26'sd32768;

    typedef logic [3:0][7:0] mpix_t;

    typedef struct packed {
        logic [7:0] y0;
        logic [7:0] y1;
        logic [7:0] cb;
        logic [7:0] cr;
    } yuv_sel_t;

    // Pick Y0, Y1, Cb, Cr out of the macropixel; unknown codes fall back to UYVY
    function automatic yuv_sel_t select_bytes(input logic [2:0] layout, input mpix_t b);
        yuv_sel_t s;
        unique case (layout)
            LAYOUT_YUYV: s = '{y0: b[0], y1: b[2], cb: b[1], cr: b[3]};
            LAYOUT_YYUV: s = '{y0: b[0], y1: b[1], cb: b[2], cr: b[3]};
            LAYOUT_YVYU: s = '{y0: b[0], y1: b[2], cb: b[3], cr: b[1]};
            LAYOUT_VYUY: s = '{y0: b[1], y1: b[3], cb: b[2], cr: b[0]};
            default:     s = '{y0: b[1], y1: b[3], cb: b[0], cr: b[2]};
        endcase
        return s;
    endfunction

    // Chroma sample minus 128, sign-extended to the product width
    function automatic logic signed [PROD_W-1:0] center(input logic [7:0] c);
        return {{(PROD_W-7){~c[7]}}, c[6:0]};
    endfunction

    // y + delta, saturated to 0..255
    function automatic logic [7:0] clamp8(input logic [7:0] y,
                                          input logic signed [DELTA_W-1:0] d);
        logic signed [SUM_W-1:0] s;
        s = $signed({{(SUM_W-8){1'b0}}, y}) + $signed({d[DELTA_W-1], d});
        if (s < 0)
            return 8'd0;
        else if (s > $signed({{(SUM_W-8){1'b0}}, MAXSAMPLE}))
            return MAXSAMPLE;
        else
            return s[7:0];
    endfunction

endpackage

// ----- design/packed_yuv422_to_rgb24_core.sv -----
`timescale 1ns / 1ps

// Channel    | Ports                                          | Transfer
// -----------+------------------------------------------------+---------------------------
// input      | start, busy, in_byte0..in_byte3                | edge with start && !busy
// result     | strobe, out_byte0..out_byte2, last_pixel       | every edge with strobe
// config     | cfg_we, cfg_index, cfg_data                    | every edge with cfg_we
//
// Sustained, one macropixel is taken per two pixels out, since the two pixels leave one
// per cycle from the output register; two transfers can land on consecutive edges when
// both stages are empty. Pixel 0 passes the capture stage (where it waits while the
// conversion stage is on pixel 0), the conversion stage and the output register; pixel 1
// follows in the next cycle. busy is high for a single cycle when the capture stage is
// full and the conversion stage is still on pixel 0. Reset clears the valid flags and
// loads the registers with layout UYVY and order R,G,B. The receiver cannot stall.
module packed_yuv422_to_rgb24_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [7:0]                            in_byte0,
    input  logic [7:0]                            in_byte1,
    input  logic [7:0]                            in_byte2,
    input  logic [7:0]                            in_byte3,
    output logic                                  strobe,
    output logic [7:0]                            out_byte0,
    output logic [7:0]                            out_byte1,
    output logic [7:0]                            out_byte2,
    output logic                                  last_pixel,
    input  logic                                  cfg_we,
    input  logic                                  cfg_index,
    input  logic [pyuv2rgb_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pyuv2rgb_pkg::*;

    // Configuration registers
    logic [2:0] yuv_layout_reg;
    logic       rgb_order_reg;

    // Capture stage: raw macropixel
    mpix_t a_bytes_reg;
    logic  a_valid_reg;

    // Conversion stage: luma pair and chroma deltas, held for pixel 0 and pixel 1
    logic [7:0]                y0_reg, y1_reg;
    logic signed [DELTA_W-1:0] dr_reg, dg_reg, db_reg;
    logic                      b_valid_reg;
    logic                      b_phase_reg;

    // Output register
    logic [7:0] out0_reg, out1_reg, out2_reg;
    logic       strobe_reg, last_reg;

    logic accept;
    logic b_take;

    yuv_sel_t                  sel;
    logic signed [PROD_W-1:0]  cb_c, cr_c;
    logic signed [PROD_W-1:0]  sum_r, sum_g, sum_b;
    logic [7:0]                y_cur;
    logic [7:0]                r_pix, g_pix, b_pix;

    // Conversion stage frees up when empty or when it sends its second pixel
    assign b_take = !b_valid_reg || b_phase_reg;
    assign busy   = a_valid_reg && !b_take;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yuv_layout_reg <= LAYOUT_UYVY;
            rgb_order_reg  <= ORDER_RGB;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_YUV_LAYOUT: yuv_layout_reg <= cfg_data[2:0];
                REG_RGB_ORDER:  rgb_order_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Capture stage: hold the macropixel until the conversion stage takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (accept)
            a_valid_reg <= 1'b1;
        else if (b_take)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            a_bytes_reg <= {in_byte3, in_byte2, in_byte1, in_byte0};
    end

    // Pick bytes and form the three rounded chroma deltas (arithmetic shift)
    always_comb
    begin
        sel   = select_bytes(yuv_layout_reg, a_bytes_reg);
        cb_c  = center(sel.cb);
        cr_c  = center(sel.cr);
        sum_r = K_CR_R * cr_c + HALF_ROUND;
        sum_b = K_CB_B * cb_c + HALF_ROUND;
        sum_g = HALF_ROUND - K_CB_G * cb_c - K_CR_G * cr_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_phase_reg <= 1'b0;
        end
        else if (b_take)
        begin
            b_valid_reg <= a_valid_reg;
            b_phase_reg <= 1'b0;
        end
        else
        begin
            // valid and on pixel 0: advance to pixel 1
            b_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_take && a_valid_reg)
        begin
            y0_reg <= sel.y0;
            y1_reg <= sel.y1;
            dr_reg <= sum_r[PROD_W-1:SCALEBITS];
            dg_reg <= sum_g[PROD_W-1:SCALEBITS];
            db_reg <= sum_b[PROD_W-1:SCALEBITS];
        end
    end

    // Pixel 0 uses Y0, pixel 1 uses Y1; chroma is shared
    always_comb
    begin
        y_cur = b_phase_reg ? y1_reg : y0_reg;
        r_pix = clamp8(y_cur, dr_reg);
        g_pix = clamp8(y_cur, dg_reg);
        b_pix = clamp8(y_cur, db_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= b_valid_reg;
            last_reg   <= b_valid_reg && b_phase_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
        begin
            out0_reg <= (rgb_order_reg == ORDER_BGR) ? b_pix : r_pix;
            out1_reg <= g_pix;
            out2_reg <= (rgb_order_reg == ORDER_BGR) ? r_pix : b_pix;
        end
    end

    assign strobe     = strobe_reg;
    assign last_pixel = last_reg;
    assign out_byte0  = out0_reg;
    assign out_byte1  = out1_reg;
    assign out_byte2  = out2_reg;

endmodule

// ----- design/pyuv2rgb_checker.sv -----
`timescale 1ns / 1ps

module pyuv2rgb_props (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic strobe,
    input logic last_pixel
);

    // Pixel 0 is always followed by pixel 1 in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_pixel |=> strobe && last_pixel)
        else $error("pixel 1 does not follow pixel 0");

    // Pixel 1 only right after pixel 0
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_pixel |-> $past(strobe) && !$past(last_pixel))
        else $error("pixel 1 without pixel 0");

    // busy never lasts more than one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held two cycles");

    // Pixel 0 traces back to an accepted transfer through the capture, conversion and output registers
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_pixel |->
            $past(start && !busy, 3) || $past(start && !busy, 4))
        else $error("result without matching input transfer");

endmodule

bind packed_yuv422_to_rgb24_core pyuv2rgb_props u_pyuv2rgb_props (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .strobe     (strobe),
    .last_pixel (last_pixel)
);
